// ===== hdl/imutcf_pkg.sv =====
// ----------------------------------------------------------------------------
// imutcf_pkg
// Types, constants and the arctangent table for the tilt complementary filter.
// ----------------------------------------------------------------------------
package imutcf_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int ATAN_LEN            = 24;

    localparam logic [31:0] GYRO_SCALE_RST   = 32'd85517602;
    localparam logic [15:0] FILTER_ALPHA_RST = 16'd62259;

    localparam logic REG_GYRO_SCALE   = 1'b0;
    localparam logic REG_FILTER_ALPHA = 1'b1;

    typedef struct packed {
        logic [7:0]         gyro_x_high;
        logic [7:0]         gyro_x_low;
        logic [7:0]         gyro_y_high;
        logic [7:0]         gyro_y_low;
        logic signed [15:0] accel_x_raw;
        logic signed [15:0] accel_y_raw;
        logic signed [15:0] accel_z_raw;
        logic [15:0]        elapsed_ticks;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] tilt_first;
        logic signed [31:0] tilt_second;
        logic signed [11:0] accel_x_counts;
        logic signed [11:0] accel_y_counts;
        logic signed [11:0] accel_z_counts;
        logic               is_new;
        logic [15:0]        ticks_out;
    } t_out_item;

    // lane command from the top level
    typedef struct packed {
        logic start;
        logic upd;
    } t_lane_ctl;

    function automatic logic [31:0] atan_q24(input logic [4:0] i);
        unique case (i)
            5'd0:  atan_q24 = 32'd754974720;
            5'd1:  atan_q24 = 32'd445687602;
            5'd2:  atan_q24 = 32'd235489088;
            5'd3:  atan_q24 = 32'd119537938;
            5'd4:  atan_q24 = 32'd60000934;
            5'd5:  atan_q24 = 32'd30029717;
            5'd6:  atan_q24 = 32'd15018523;
            5'd7:  atan_q24 = 32'd7509720;
            5'd8:  atan_q24 = 32'd3754917;
            5'd9:  atan_q24 = 32'd1877466;
            5'd10: atan_q24 = 32'd938734;
            5'd11: atan_q24 = 32'd469367;
            5'd12: atan_q24 = 32'd234684;
            5'd13: atan_q24 = 32'd117342;
            5'd14: atan_q24 = 32'd58671;
            5'd15: atan_q24 = 32'd29335;
            5'd16: atan_q24 = 32'd14668;
            5'd17: atan_q24 = 32'd7334;
            5'd18: atan_q24 = 32'd3667;
            5'd19: atan_q24 = 32'd1833;
            5'd20: atan_q24 = 32'd917;
            5'd21: atan_q24 = 32'd458;
            5'd22: atan_q24 = 32'd229;
            5'd23: atan_q24 = 32'd115;
            default: atan_q24 = 32'd0;
        endcase
    endfunction

    function automatic logic [15:0] gyro_rate(input logic [7:0] hi, input logic [7:0] lo);
        if (hi == 8'd0 || hi == 8'hFF) begin
            gyro_rate = 16'd0;
        end else begin
            gyro_rate = {hi, lo};
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

// ===== hdl/imu_tilt_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter
// Two-axis tilt estimate: gyro integration blended with CORDIC accel tilt.
// Input stalls while the lanes work on an item, so the next item is taken only
// after the CORDIC loop and blend of the last one are done.
// Both axes run in parallel lanes; the result register frees input early.
// Reset clears all filter state and loads the register defaults.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter #(
    parameter int CORDIC_STEPS    = imutcf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = imutcf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  imutcf_pkg::t_in_item  i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output imutcf_pkg::t_out_item o_item,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [31:0]           i_cfg_data
);
    logic                  r_busy;
    logic [31:0]           r_scale;
    logic [15:0]           r_alpha;
    logic [11:0]           r_prev_x, r_prev_y, r_prev_z;
    imutcf_pkg::t_in_item  r_in;
    imutcf_pkg::t_out_item r_rest;
    imutcf_pkg::t_lane_ctl w_ctl;
    logic                  w_acc, w_done_a, w_done_b;
    logic signed [31:0]    w_ta, w_tb;
    logic signed [11:0]    w_cx, w_cy, w_cz;

    assign w_cx  = i_item.accel_x_raw[15:4];
    assign w_cy  = i_item.accel_y_raw[15:4];
    assign w_cz  = i_item.accel_z_raw[15:4];
    assign o_stall = r_busy || (o_valid && i_stall);
    assign w_acc = i_valid && !o_stall;
    assign w_ctl.start = w_acc;
    assign w_ctl.upd   = (w_cx != 12'sd0) && (w_cy != 12'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_scale  <= imutcf_pkg::GYRO_SCALE_RST;
            r_alpha  <= imutcf_pkg::FILTER_ALPHA_RST;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_prev_z <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == imutcf_pkg::REG_GYRO_SCALE) begin
                    r_scale <= i_cfg_data;
                end else begin
                    r_alpha <= i_cfg_data[15:0];
                end
            end
            if (w_acc) begin
                r_busy   <= 1'b1;
                r_in     <= i_item;
                r_prev_x <= w_cx;
                r_prev_y <= w_cy;
                r_prev_z <= w_cz;
                r_rest.tilt_first     <= '0;
                r_rest.tilt_second    <= '0;
                r_rest.accel_x_counts <= w_cx;
                r_rest.accel_y_counts <= w_cy;
                r_rest.accel_z_counts <= w_cz;
                r_rest.is_new    <= (w_cx != r_prev_x) || (w_cy != r_prev_y)
                                 || (w_cz != r_prev_z);
                r_rest.ticks_out <= i_item.elapsed_ticks;
            end else if (w_done_a) begin
                r_busy <= 1'b0;
            end
        end
    end

    imutcf_lane #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_a (
        .i_clk, .i_rst_n, .i_ctl(w_ctl),
        .i_rate(w_acc ? imutcf_pkg::gyro_rate(i_item.gyro_x_high, i_item.gyro_x_low)
                      : 16'd0),
        .i_ticks(r_in.elapsed_ticks), .i_num(w_cz), .i_den(w_cy),
        .i_scale(r_scale), .i_alpha(r_alpha), .o_done(w_done_a), .o_tilt(w_ta)
    );

    imutcf_lane #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_b (
        .i_clk, .i_rst_n, .i_ctl(w_ctl),
        .i_rate(w_acc ? imutcf_pkg::gyro_rate(i_item.gyro_y_high, i_item.gyro_y_low)
                      : 16'd0),
        .i_ticks(r_in.elapsed_ticks), .i_num(w_cz), .i_den(w_cx),
        .i_scale(r_scale), .i_alpha(r_alpha), .o_done(w_done_b), .o_tilt(w_tb)
    );

    imutcf_merge u_merge (
        .i_clk, .i_rst_n, .i_load(w_done_a && w_done_b),
        .i_tilt_a(w_ta), .i_tilt_b(w_tb), .i_rest(r_rest),
        .i_stall, .o_valid, .o_item
    );
endmodule

// ===== hdl/imutcf_lane.sv =====
// ----------------------------------------------------------------------------
// imutcf_lane
// One axis: gyro increment by serial multiply, CORDIC arctangent, blend.
// ----------------------------------------------------------------------------
module imutcf_lane #(
    parameter int CORDIC_STEPS    = imutcf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = imutcf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  imutcf_pkg::t_lane_ctl i_ctl,
    input  logic [15:0]           i_rate,
    input  logic [15:0]           i_ticks,
    input  logic signed [11:0]    i_num,
    input  logic signed [11:0]    i_den,
    input  logic [31:0]           i_scale,
    input  logic [15:0]           i_alpha,
    output logic                  o_done,
    output logic signed [31:0]    o_tilt
);
    localparam int NSTEP = (CORDIC_STEPS < imutcf_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                                 : imutcf_pkg::ATAN_LEN;
    localparam int SH    = 24 - ANGLE_FRAC_BITS;
    localparam int GSH   = 48 - ANGLE_FRAC_BITS;

    typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_CORD, S_BL1, S_BL2, S_BL3} t_state;

    t_state              r_state;
    logic [4:0]          r_i;
    logic signed [15:0]  r_prev;
    logic                r_neg, r_nz;
    logic [16:0]         r_mag;
    logic [32:0]         r_p1;
    logic [64:0]         r_p2;
    logic signed [63:0]  r_inc;
    logic signed [27:0]  r_x, r_y;
    logic signed [31:0]  r_ang;
    logic signed [31:0]  r_acc, r_filt;
    logic signed [63:0]  r_b1;
    logic                r_upd;

    logic signed [16:0]  w_sum;
    logic signed [27:0]  w_dx, w_dy;
    logic signed [31:0]  w_t;
    logic [31:0]         w_tab;
    logic [64:0]         w_q;
    logic                w_rem;
    logic signed [63:0]  w_b2;

    assign w_sum = $signed({i_rate[15], i_rate}) + $signed({r_prev[15], r_prev});
    assign w_dx  = r_y >>> r_i;
    assign w_dy  = r_x >>> r_i;
    assign w_tab = imutcf_pkg::atan_q24(r_i);
    assign w_t   = 32'((w_tab + (32'd1 << (SH - 1))) >> SH);
    assign w_q   = r_p2 >> GSH;
    assign w_rem = |(r_p2 & ((65'd1 << GSH) - 65'd1));
    assign w_b2  = r_b1 + $signed({1'b0, 17'(18'd65536 - {2'b0, i_alpha})}) * r_acc;
    assign o_tilt = r_filt;

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prev  <= '0;
            r_acc   <= '0;
            r_filt  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_nz   <= (i_rate != 16'd0) && (r_prev != 16'sd0);
                        r_neg  <= w_sum[16];
                        r_mag  <= w_sum[16] ? 17'(-w_sum) : 17'(w_sum);
                        r_prev <= i_rate;
                        r_upd  <= i_ctl.upd;
                        r_x    <= i_den[11] ? 28'(-$signed(i_den)) <<< 10
                                            : 28'($signed(i_den)) <<< 10;
                        r_y    <= i_den[11] ? 28'(-$signed(i_num)) <<< 10
                                            : 28'($signed(i_num)) <<< 10;
                        r_ang  <= '0;
                        r_i    <= '0;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p1    <= 33'(r_mag) * 33'(i_ticks);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= 65'(r_p1) * 65'(i_scale);
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_i == 5'd0) begin
                        if (!r_nz) begin
                            r_inc <= '0;
                        end else if (!r_neg) begin
                            r_inc <= $signed(w_q[63:0]);
                        end else begin
                            r_inc <= -$signed(w_q[63:0] + 64'(w_rem));
                        end
                    end
                    if (r_y > 0) begin
                        r_x <= r_x + w_dx; r_y <= r_y - w_dy; r_ang <= r_ang + w_t;
                    end else begin
                        r_x <= r_x - w_dx; r_y <= r_y + w_dy; r_ang <= r_ang - w_t;
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(NSTEP - 1)) begin
                        r_state <= S_BL1;
                    end
                end
                S_BL1: begin
                    if (r_upd) begin
                        r_acc <= -r_ang;
                    end
                    r_state <= S_BL2;
                end
                S_BL2: begin
                    r_b1    <= $signed({1'b0, i_alpha}) * (64'(r_filt) + r_inc);
                    r_state <= S_BL3;
                end
                S_BL3: begin
                    r_filt  <= imutcf_pkg::sat32(w_b2 >>> 16);
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== hdl/imut_merge.sv =====
// ----------------------------------------------------------------------------
// imutcf_merge
// Combine the lane tilts with the counts into one result item.
// ----------------------------------------------------------------------------
module imutcf_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic signed [31:0]    i_tilt_a,
    input  logic signed [31:0]    i_tilt_b,
    input  imutcf_pkg::t_out_item i_rest,
    input  logic                  i_stall,
    output logic                  o_valid,
    output imutcf_pkg::t_out_item o_item
);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_load) begin
            o_valid <= 1'b1;
            o_item  <= {i_tilt_a, i_tilt_b, i_rest.accel_x_counts, i_rest.accel_y_counts,
                        i_rest.accel_z_counts, i_rest.is_new, i_rest.ticks_out};
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end
endmodule

// ===== dv/imu_tilt_complementary_filter_tb.sv =====
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter_tb
// Checks the tilt filter against its own predictor of gyro integration, CORDIC
// accel tilt and per-axis blending. Directed corner samples come first, then
// random sample streams under several register settings, with random idling
// on both sides, a long output hold-off and a drain before every setting.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 900000;
    localparam int  SETTLE      = 40;
    localparam int  TILT_STEPS  = 16;

    class tilt_scoreboard;
        imutcf_pkg::t_out_item pending[$];
        logic [31:0] scale;
        logic [15:0] alpha;
        int          rate_x, rate_y;
        int          filt_first, filt_second, acc_first, acc_second;
        int          last_cnt[3];
        int          errors, n_in, n_out;
        longint      atan_tab[24] = '{
            754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
            15018523, 7509720, 3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334,
            3667, 1833, 917, 458, 229, 115};

        function void clear();
            scale = imutcf_pkg::GYRO_SCALE_RST;
            alpha = imutcf_pkg::FILTER_ALPHA_RST;
            rate_x = 0; rate_y = 0;
            filt_first = 0; filt_second = 0;
            acc_first = 0; acc_second = 0;
            last_cnt = '{0, 0, 0};
        endfunction

        function void set_reg(logic idx, logic [31:0] data);
            if (idx == imutcf_pkg::REG_GYRO_SCALE) begin
                scale = data;
            end else begin
                alpha = data[15:0];
            end
        endfunction

        function int rate_of(logic [7:0] hi, logic [7:0] lo);
            logic signed [15:0] w;
            w = {hi, lo};
            if (hi == 8'h00 || hi == 8'hFF) begin
                return 0;
            end
            return int'(w);
        endfunction

        function int clip(logic signed [127:0] v);
            if (v > 128'sd2147483647) begin
                return 32'h7FFFFFFF;
            end else if (v < -128'sd2147483648) begin
                return 32'h80000000;
            end
            return int'(v);
        endfunction

        function longint step_angle(int r, int pr, logic [15:0] ticks);
            logic signed [127:0] p, t, s;
            if (r == 0 || pr == 0) begin
                return 0;
            end
            p = r + pr;
            t = {112'd0, ticks};
            s = {96'd0, scale};
            p = p * t * s;
            p = p >>> 32;
            return longint'(p);
        endfunction

        function int neg_atan(int n, int d);
            longint x, y, ang, t, dx, dy;
            x = (d < 0 ? -d : d) * 1024;
            y = (d < 0 ? -n : n) * 1024;
            ang = 0;
            for (int i = 0; i < TILT_STEPS; i++) begin
                t = (atan_tab[i] + 128) >>> 8;
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; ang += t;
                end else begin
                    x -= dx; y += dy; ang -= t;
                end
            end
            return clip(-ang);
        endfunction

        function int mix(int filt, longint inc, int acc);
            logic signed [127:0] a, b, v;
            a = {112'd0, alpha};
            b = 128'sd65536 - a;
            v = a * (128'(signed'(filt)) + 128'(signed'(inc))) + b * 128'(signed'(acc));
            return clip(v >>> 16);
        endfunction

        function void note_sample(imutcf_pkg::t_in_item it);
            imutcf_pkg::t_out_item e;
            int        rx, ry, cnt[3];
            longint    ix, iy;
            bit        fresh;
            rx = rate_of(it.gyro_x_high, it.gyro_x_low);
            ry = rate_of(it.gyro_y_high, it.gyro_y_low);
            cnt[0] = int'($signed(it.accel_x_raw[15:4]));
            cnt[1] = int'($signed(it.accel_y_raw[15:4]));
            cnt[2] = int'($signed(it.accel_z_raw[15:4]));
            ix = step_angle(rx, rate_x, it.elapsed_ticks);
            iy = step_angle(ry, rate_y, it.elapsed_ticks);
            rate_x = rx;
            rate_y = ry;
            if (cnt[0] != 0 && cnt[1] != 0) begin
                acc_first = neg_atan(cnt[2], cnt[1]);
                acc_second = neg_atan(cnt[2], cnt[0]);
            end
            filt_first = mix(filt_first, ix, acc_first);
            filt_second = mix(filt_second, iy, acc_second);
            fresh = 0;
            for (int k = 0; k < 3; k++) begin
                if (cnt[k] != last_cnt[k]) fresh = 1;
                last_cnt[k] = cnt[k];
            end
            e.tilt_first = filt_first;
            e.tilt_second = filt_second;
            e.accel_x_counts = cnt[0][11:0];
            e.accel_y_counts = cnt[1][11:0];
            e.accel_z_counts = cnt[2][11:0];
            e.is_new = fresh;
            e.ticks_out = it.elapsed_ticks;
            pending.push_back(e);
            n_in++;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at result %0d: %s got %h expected %h", n_out, what, got, want);
            errors++;
        endtask

        task check_result(imutcf_pkg::t_out_item got);
            imutcf_pkg::t_out_item e;
            if (pending.size() == 0) begin
                $display("unexpected result %0d: %h", n_out, got);
                errors++;
                n_out++;
                return;
            end
            e = pending.pop_front();
            if (got.tilt_first !== e.tilt_first)
                report("tilt_first", got.tilt_first, e.tilt_first);
            if (got.tilt_second !== e.tilt_second)
                report("tilt_second", got.tilt_second, e.tilt_second);
            if (got.accel_x_counts !== e.accel_x_counts)
                report("accel_x_counts", got.accel_x_counts, e.accel_x_counts);
            if (got.accel_y_counts !== e.accel_y_counts)
                report("accel_y_counts", got.accel_y_counts, e.accel_y_counts);
            if (got.accel_z_counts !== e.accel_z_counts)
                report("accel_z_counts", got.accel_z_counts, e.accel_z_counts);
            if (got.is_new !== e.is_new)
                report("is_new", got.is_new, e.is_new);
            if (got.ticks_out !== e.ticks_out)
                report("ticks_out", got.ticks_out, e.ticks_out);
            n_out++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    imutcf_pkg::t_in_item  i_item;
    logic                  o_valid;
    logic                  i_stall;
    imutcf_pkg::t_out_item o_item;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [31:0]           i_cfg_data;

    tilt_scoreboard sb;
    bit             calm;
    bit             long_hold_req;
    int             hold_left;
    int             cycles;

    imu_tilt_complementary_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** imu_tilt_complementary_filter: FAILED **");
            $finish;
        end
    end

    // output side: random hold-off bursts plus one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (long_hold_req) begin
            long_hold_req = 0;
            hold_left = 300;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(0, 17);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_item);
        end
    end

    function automatic imutcf_pkg::t_in_item sample(bit [7:0] xh, bit [7:0] xl, bit [7:0] yh,
                                                    bit [7:0] yl, bit [15:0] ax, bit [15:0] ay,
                                                    bit [15:0] az, bit [15:0] tk);
        imutcf_pkg::t_in_item it;
        it = {xh, xl, yh, yl, ax, ay, az, tk};
        return it;
    endfunction

    function automatic imutcf_pkg::t_in_item random_sample();
        imutcf_pkg::t_in_item it;
        it = {$urandom, $urandom, $urandom, 16'($urandom)};
        if ($urandom_range(0, 99) < 85) begin
            it.gyro_x_high = 8'($urandom_range(1, 254));
            it.gyro_y_high = 8'($urandom_range(1, 254));
            if (it.accel_x_raw[15:4] == 0) it.accel_x_raw[15:4] = 12'h7FF;
            if (it.accel_y_raw[15:4] == 0) it.accel_y_raw[15:4] = 12'h800;
            case ($urandom_range(0, 9))
                0: it.elapsed_ticks = 16'd0;
                1: it.elapsed_ticks = 16'hFFFF;
                2, 3, 4: it.elapsed_ticks = 16'($urandom_range(50, 400));
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic push(imutcf_pkg::t_in_item it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(it);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] scale, logic [15:0] alpha, int n, bit hold);
        drain();
        write_reg(imutcf_pkg::REG_GYRO_SCALE, scale);
        write_reg(imutcf_pkg::REG_FILTER_ALPHA, alpha);
        for (int i = 0; i < n; i++) begin
            if (hold && i == 50) long_hold_req = 1;
            push(random_sample());
        end
    endtask

    initial begin
        imutcf_pkg::t_in_item directed[$];
        sb = new();
        sb.clear();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = imutcf_pkg::REG_GYRO_SCALE;
        i_cfg_data = '0;
        calm = 0;
        long_hold_req = 0;
        hold_left = 0;
        cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // dead band, trapezoid start-up, zero counts, repeats, extremes
        directed.push_back(sample(8'h00, 8'hFF, 8'hFF, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd100));
        directed.push_back(sample(8'h01, 8'h00, 8'hFE, 8'hFF, 16'h1000, 16'h2000, 16'h3000, 16'd100));
        directed.push_back(sample(8'h7F, 8'hFF, 8'h80, 8'h00, 16'h1000, 16'h2000, 16'h3000, 16'd0));
        directed.push_back(sample(8'h7F, 8'hFF, 8'h80, 8'h00, 16'h1000, 16'h2000, 16'h3000, 16'hFFFF));
        directed.push_back(sample(8'h80, 8'h00, 8'h7F, 8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        directed.push_back(sample(8'h80, 8'h00, 8'h80, 8'h00, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
        directed.push_back(sample(8'h00, 8'h12, 8'h40, 8'h00, 16'h000F, 16'h4000, 16'h1230, 16'd10));
        directed.push_back(sample(8'h40, 8'h00, 8'h40, 8'h00, 16'h4000, 16'h000F, 16'hEDC0, 16'd10));
        directed.push_back(sample(8'h40, 8'h00, 8'hC0, 8'h00, 16'h4000, 16'h4000, 16'h0000, 16'd300));
        directed.push_back(sample(8'hC0, 8'h00, 8'hC0, 8'h00, 16'hC000, 16'h4000, 16'h0000, 16'd300));
        directed.push_back(sample(8'hC0, 8'h00, 8'hFF, 8'hFF, 16'h4000, 16'hC000, 16'h7FF0, 16'd300));
        directed.push_back(sample(8'h01, 8'h01, 8'h01, 8'h01, 16'hFFF0, 16'h0010, 16'h8000, 16'd1));
        directed.push_back(sample(8'hFE, 8'h00, 8'h01, 8'h00, 16'h0010, 16'hFFF0, 16'hFFF0, 16'd1));
        directed.push_back(sample(8'hFE, 8'h00, 8'h01, 8'h00, 16'h0010, 16'hFFF0, 16'hFFF0, 16'd2));
        directed.push_back(sample(8'h55, 8'hAA, 8'hAA, 8'h55, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        directed.push_back(sample(8'hAA, 8'h55, 8'h55, 8'hAA, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        foreach (directed[i]) push(directed[i]);

        run_phase(imutcf_pkg::GYRO_SCALE_RST, imutcf_pkg::FILTER_ALPHA_RST, 400, 1);
        run_phase(32'hFFFFFFFF, 16'h0000, 300, 0);
        run_phase(32'h00000000, 16'hFFFF, 300, 0);
        run_phase($urandom, 16'($urandom), 300, 0);
        drain();
        calm = 1;
        run_phase($urandom, 16'($urandom_range(60000, 65535)), 300, 0);
        drain();

        $display("%0d samples sent, %0d results checked over five register settings",
                 sb.n_in, sb.n_out);
        $display("covered dead band, zero counts, tick extremes, saturation and long hold-off");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("** imu_tilt_complementary_filter: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("** imu_tilt_complementary_filter: FAILED **");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/imutcf_pkg.sv
hdl/imutcf_lane.sv
hdl/imut_merge.sv
hdl/imu_tilt_complementary_filter.sv
dv/imu_tilt_complementary_filter_tb.sv
